@@ rtl/assert_macros.svh @@
// Assertion helpers, included by the engine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/tqs_pkg.sv @@
// ----------------------------------------------------------------------------
// tqs_pkg
// Types and constants for the three-way quicksort engine.
// ----------------------------------------------------------------------------
`default_nettype none
package tqs_pkg;
	localparam int unsigned TAG_W  = 16;
	localparam int unsigned OUTK_W = 32;

	localparam logic REG_SIGNED     = 1'b0;
	localparam logic REG_DESCENDING = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PUSH0,
		ST_POP,
		ST_POPW,
		ST_PIV,
		ST_RD,
		ST_CMP,
		ST_SWPW,
		ST_PUSH1,
		ST_PUSH2,
		ST_OUTRD,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

@@ rtl/tqs_elem_mem.sv @@
// ----------------------------------------------------------------------------
// tqs_elem_mem
// Element store: key and tag, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tqs_elem_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned KW    = 32,
	parameter int unsigned AW    = 6
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [KW-1:0]            wkey,
	input  wire logic [tqs_pkg::TAG_W-1:0] wtag,
	input  wire logic [AW-1:0]            raddr,
	output logic      [KW-1:0]            rkey,
	output logic      [tqs_pkg::TAG_W-1:0] rtag
);
	logic [KW-1:0]             key_mem [DEPTH];
	logic [tqs_pkg::TAG_W-1:0] tag_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			tag_mem[waddr] <= wtag;
		end
		rkey <= key_mem[raddr];
		rtag <= tag_mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/tqs_stack_mem.sv @@
// ----------------------------------------------------------------------------
// tqs_stack_mem
// Range stack: pending (lo, hi) pairs, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module tqs_stack_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/three_way_quicksort_engine_core.sv @@
// ----------------------------------------------------------------------------
// three_way_quicksort_engine_core
// Loads elements, sorts them by 3-way quicksort with a range stack, emits them.
// ----------------------------------------------------------------------------
// Loading takes one cycle per item; busy stays low between loads.
// After the item marked last, the sort reads and compares each element, and a compare
// that leads to a swap takes a further write state (one read, then two writes on the
// single element port); each popped range adds pop, pivot and push states, and the sort
// has a start and a finish state. Then the n results are read out through the read port.
// The receiver cannot stall. Reset clears counts, flags, config and the state machine only.
`default_nettype none
module three_way_quicksort_engine_core #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned KEY_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] key,
	input  wire logic [15:0] tag,
	input  wire logic        last_item,
	output logic             result_valid,
	output logic [31:0]      sorted_key,
	output logic [15:0]      sorted_tag,
	output logic             last_result,
	output logic             overflowed,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [0:0]  cfg_data
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = 2 * AW;
	localparam int unsigned SDW = $clog2(CAPACITY + 1);

	tqs_pkg::state_t state_q, state_d;

	logic signed_q, desc_q;
	logic [CW-1:0]  count_q;
	logic           ovf_q;
	logic [SDW-1:0] sp_q;
	logic [AW-1:0]  lo_q, hi_q, lt_q, i_q, gt_q, oidx_q;
	logic [KEY_BITS-1:0] pivot_q;

	// Element memory port signals.
	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [KEY_BITS-1:0] wkey, rkey;
	logic [15:0]         wtag, rtag;
	// Stack port signals.
	logic          swe;
	logic [AW-1:0] swaddr, sraddr;
	logic [SW-1:0] swdata, srdata;

	logic [KEY_BITS-1:0] key_in;
	if (KEY_BITS > 32) begin : g_wide
		assign key_in = KEY_BITS'(key);
	end else begin : g_narrow
		assign key_in = key[KEY_BITS-1:0];
	end

	tqs_elem_mem #(.DEPTH(CAPACITY), .KW(KEY_BITS), .AW(AW)) u_elem (
		.clk(clk), .we(we), .waddr(waddr), .wkey(wkey), .wtag(wtag),
		.raddr(raddr), .rkey(rkey), .rtag(rtag)
	);

	tqs_stack_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(SW)) u_stack (
		.clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
		.raddr(sraddr), .rdata(srdata)
	);

	// Compare of the element just read against the pivot.
	logic [KEY_BITS-1:0] ca, cb;
	logic                c_lt, c_gt;
	always_comb begin
		ca = rkey;
		cb = pivot_q;
		if (signed_q) begin
			ca[KEY_BITS-1] = ~ca[KEY_BITS-1];
			cb[KEY_BITS-1] = ~cb[KEY_BITS-1];
		end
		c_lt = desc_q ? (ca > cb) : (ca < cb);
		c_gt = desc_q ? (ca < cb) : (ca > cb);
	end

	logic accept;
	assign busy   = (state_q != tqs_pkg::ST_LOAD);
	assign accept = start && !busy;
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b0;
			desc_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tqs_pkg::REG_SIGNED) begin
				signed_q <= cfg_data[0];
			end else begin
				desc_q <= cfg_data[0];
			end
		end
	end

	// Swap bookkeeping: a swap writes the read element to the far slot in
	// ST_CMP, which also reads the old far element; ST_SWPW writes that one
	// back to slot i.
	logic          swap_q;
	logic [AW-1:0] ltm1, gtp1, last_idx;
	logic          lt_gt_lo, hi_gt_gt;

	assign ltm1     = lt_q - AW'(1);
	assign gtp1     = gt_q + AW'(1);
	assign last_idx = AW'(count_q - CW'(1));
	// A part is pushed only when it holds at least two elements.
	assign lt_gt_lo = (lt_q != lo_q) && (ltm1 > lo_q);
	assign hi_gt_gt = (hi_q != gt_q) && (hi_q > gtp1);

	always_comb begin
		state_d = state_q;
		we = 1'b0; waddr = i_q; wkey = rkey; wtag = rtag;
		raddr = i_q;
		swe = 1'b0; swaddr = sp_q[AW-1:0]; swdata = {lo_q, hi_q};
		sraddr = AW'(sp_q - SDW'(1));
		case (state_q)
			tqs_pkg::ST_LOAD: begin
				waddr = count_q[AW-1:0];
				wkey  = key_in;
				wtag  = tag;
				we    = accept && (count_q < CW'(CAPACITY));
				if (accept && last_item) begin
					state_d = tqs_pkg::ST_PUSH0;
				end
			end
			tqs_pkg::ST_PUSH0: begin
				swaddr = '0;
				swdata = {AW'(0), last_idx};
				swe    = (count_q > CW'(1));
				state_d = (count_q > CW'(1)) ? tqs_pkg::ST_POP : tqs_pkg::ST_OUTRD;
			end
			tqs_pkg::ST_POP: begin
				state_d = (sp_q == '0) ? tqs_pkg::ST_OUTRD : tqs_pkg::ST_POPW;
			end
			tqs_pkg::ST_POPW: begin
				raddr = srdata[SW-1:AW];
				state_d = tqs_pkg::ST_PIV;
			end
			tqs_pkg::ST_PIV: begin
				raddr = AW'(lo_q + AW'(1));
				state_d = tqs_pkg::ST_RD;
			end
			tqs_pkg::ST_RD: begin
				state_d = tqs_pkg::ST_CMP;
			end
			tqs_pkg::ST_CMP: begin
				// rkey holds element i.
				if (c_lt) begin
					waddr = lt_q; we = 1'b1;
					raddr = lt_q;
				end else if (c_gt) begin
					waddr = gt_q; we = 1'b1;
					raddr = gt_q;
				end
				state_d = (c_lt || c_gt) ? tqs_pkg::ST_SWPW : tqs_pkg::ST_RD;
				if (!(c_lt || c_gt)) begin
					raddr = AW'(i_q + AW'(1));
					if (i_q == gt_q) begin
						state_d = tqs_pkg::ST_PUSH1;
					end
				end
			end
			tqs_pkg::ST_SWPW: begin
				// rkey holds the old far element, read before its overwrite.
				waddr = i_q; we = 1'b1;
				raddr = swap_q ? AW'(i_q + AW'(1)) : i_q;
				state_d = tqs_pkg::ST_RD;
				if (swap_q ? (i_q == gt_q) : (AW'(i_q) == gtp1)) begin
					state_d = tqs_pkg::ST_PUSH1;
				end
			end
			tqs_pkg::ST_PUSH1: begin
				swdata = {lo_q, ltm1};
				swe    = lt_gt_lo;
				state_d = tqs_pkg::ST_PUSH2;
			end
			tqs_pkg::ST_PUSH2: begin
				swdata = {gtp1, hi_q};
				swe    = hi_gt_gt;
				state_d = tqs_pkg::ST_POP;
			end
			tqs_pkg::ST_OUTRD: begin
				raddr = oidx_q;
				state_d = tqs_pkg::ST_OUT;
			end
			tqs_pkg::ST_OUT: begin
				state_d = (oidx_q == last_idx) ? tqs_pkg::ST_LOAD : tqs_pkg::ST_OUTRD;
			end
			default: state_d = tqs_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			sp_q    <= '0;
			oidx_q  <= '0;
			swap_q  <= 1'b0;
		end else begin
			case (state_q)
				tqs_pkg::ST_LOAD: begin
					if (accept) begin
						if (count_q < CW'(CAPACITY)) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					sp_q <= '0;
					oidx_q <= '0;
				end
				tqs_pkg::ST_PUSH0: begin
					if (count_q > CW'(1)) begin
						sp_q <= SDW'(1);
					end
				end
				tqs_pkg::ST_POP: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - SDW'(1);
					end
				end
				tqs_pkg::ST_CMP: begin
					swap_q <= c_lt;
				end
				tqs_pkg::ST_PUSH1: begin
					if (lt_gt_lo) begin
						sp_q <= sp_q + SDW'(1);
					end
				end
				tqs_pkg::ST_PUSH2: begin
					if (hi_gt_gt) begin
						sp_q <= sp_q + SDW'(1);
					end
				end
				tqs_pkg::ST_OUT: begin
					oidx_q <= oidx_q + AW'(1);
					if (oidx_q == last_idx) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Range pointers and pivot.
	always_ff @(posedge clk) begin
		case (state_q)
			tqs_pkg::ST_POPW: begin
				lo_q <= srdata[SW-1:AW];
				hi_q <= srdata[AW-1:0];
				lt_q <= srdata[SW-1:AW];
				gt_q <= srdata[AW-1:0];
				i_q  <= AW'(srdata[SW-1:AW] + AW'(1));
			end
			tqs_pkg::ST_PIV: begin
				pivot_q <= rkey;
			end
			tqs_pkg::ST_CMP: begin
				if (c_lt) begin
					lt_q <= lt_q + AW'(1);
				end else if (c_gt) begin
					gt_q <= gt_q - AW'(1);
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
			tqs_pkg::ST_SWPW: begin
				// Element i now holds the old far element; after a "less" swap
				// it is equal to the pivot, so i advances.
				if (swap_q) begin
					i_q <= i_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == tqs_pkg::ST_OUT);
		end
	end

	localparam int unsigned OUTW = 32;
	logic [OUTW-1:0] okey;
	if (KEY_BITS >= 32) begin : g_okw
		assign okey = rkey[31:0];
	end else begin : g_okn
		assign okey = 32'(rkey);
	end

	always_ff @(posedge clk) begin
		if (state_q == tqs_pkg::ST_OUT) begin
			sorted_key  <= okey;
			sorted_tag  <= rtag;
			last_result <= (oidx_q == last_idx);
			overflowed  <= ovf_q;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_cfg_idle, clk, arst_n, cfg_ready, !busy, "config taken while busy")
	`ASSERT_IMPL(a_cnt_cap, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count past capacity")
	`ASSERT_NEXT(a_res_out, clk, arst_n, result_valid && last_result, !result_valid,
		"result after last")
	`ASSERT_IMPL(a_ptr, clk, arst_n, state_q == tqs_pkg::ST_RD, lt_q <= i_q,
		"partition pointers crossed")
endmodule
`default_nettype wire

@@ tb/three_way_quicksort_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// three_way_quicksort_engine_core_tb
// Self-checking bench: loads element sets, predicts the sorted run by an own
// 3-way partitioning sort with a range stack, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: holds a shadow copy of the element store and the queue of
// sorted elements still owed by the block.
class sort_scoreboard;
	logic [31:0] keys[64];
	logic [15:0] tags[64];
	int unsigned count;
	bit ovf;
	bit sgn;
	bit desc;
	logic [31:0] exp_key[$];
	logic [15:0] exp_tag[$];
	bit exp_last[$];
	bit exp_ovf[$];
	int errors;

	function new();
		count = 0;
		ovf = 0;
		sgn = 0;
		desc = 0;
		errors = 0;
	endfunction

	function int order(logic [31:0] a, logic [31:0] b);
		int c;
		if (sgn) begin
			a[31] = ~a[31];
			b[31] = ~b[31];
		end
		c = (a < b) ? -1 : ((a > b) ? 1 : 0);
		return desc ? -c : c;
	endfunction

	function void swap_at(int p, int q);
		logic [31:0] k;
		logic [15:0] t;
		k = keys[p];
		t = tags[p];
		keys[p] = keys[q];
		tags[p] = tags[q];
		keys[q] = k;
		tags[q] = t;
	endfunction

	// The stack order must match the block: the lower part is pushed first,
	// so the upper part is partitioned next.
	function void sort_store();
		int lo_s[$];
		int hi_s[$];
		int lo, hi, lt, i, gt, c;
		logic [31:0] pv;
		if (count > 1) begin
			lo_s.push_back(0);
			hi_s.push_back(count - 1);
		end
		while (lo_s.size() > 0) begin
			lo = lo_s.pop_back();
			hi = hi_s.pop_back();
			lt = lo;
			i = lo + 1;
			gt = hi;
			pv = keys[lo];
			while (i <= gt) begin
				c = order(keys[i], pv);
				if (c < 0) begin
					swap_at(lt, i);
					lt++;
					i++;
				end else if (c > 0) begin
					swap_at(i, gt);
					gt--;
				end else begin
					i++;
				end
			end
			if (lo < lt - 1) begin
				lo_s.push_back(lo);
				hi_s.push_back(lt - 1);
			end
			if (gt + 1 < hi) begin
				lo_s.push_back(gt + 1);
				hi_s.push_back(hi);
			end
		end
	endfunction

	function void note_item(logic [31:0] k, logic [15:0] t, bit last);
		if (count < 64) begin
			keys[count] = k;
			tags[count] = t;
			count++;
		end else begin
			ovf = 1;
		end
		if (last) begin
			sort_store();
			for (int n = 0; n < count; n++) begin
				exp_key.push_back(keys[n]);
				exp_tag.push_back(tags[n]);
				exp_last.push_back(n == count - 1);
				exp_ovf.push_back(ovf);
			end
			count = 0;
			ovf = 0;
		end
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task check_result(logic [31:0] k, logic [15:0] t, bit l, bit o);
		if (exp_key.size() == 0) begin
			report("unexpected result", k, 0);
			return;
		end
		if (k !== exp_key[0]) report("sorted_key", k, exp_key[0]);
		if (t !== exp_tag[0]) report("sorted_tag", 32'(t), 32'(exp_tag[0]));
		if (l !== exp_last[0]) report("last_result", 32'(l), 32'(exp_last[0]));
		if (o !== exp_ovf[0]) report("overflowed", 32'(o), 32'(exp_ovf[0]));
		void'(exp_key.pop_front());
		void'(exp_tag.pop_front());
		void'(exp_last.pop_front());
		void'(exp_ovf.pop_front());
	endtask
endclass

module three_way_quicksort_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [31:0] key;
	logic [15:0] tag;
	logic last_item;
	logic result_valid;
	logic [31:0] sorted_key;
	logic [15:0] sorted_tag;
	logic last_result;
	logic overflowed;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [0:0] cfg_data;

	sort_scoreboard board;
	// Percentage of cycles in which the sender leaves start low.
	int idle_pct;
	int items_sent;

	three_way_quicksort_engine_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.key(key), .tag(tag), .last_item(last_item),
		.result_valid(result_valid), .sorted_key(sorted_key),
		.sorted_tag(sorted_tag), .last_result(last_result),
		.overflowed(overflowed), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Results cannot be held off, so they are checked at every strobed edge.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_result(sorted_key, sorted_tag, last_result, overflowed);
	end

	// Writes one configuration register; only used while the block is idle.
	task automatic write_reg(logic idx, logic val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == tqs_pkg::REG_SIGNED) board.sgn = val;
		else board.desc = val;
		cfg_valid <= 0;
	endtask

	// Offers one element and holds it until the block takes it. Random idle
	// cycles are inserted before the offer. start stays high back to back
	// when no idle cycle falls between two items.
	task automatic send_item(logic [31:0] k, logic [15:0] t, bit last);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		key <= k;
		tag <= t;
		last_item <= last;
		do @(posedge clk); while (busy);
		board.note_item(k, t, last);
		items_sent++;
	endtask

	// Waits until the sorted run has come out, plus a short drain pause.
	task automatic drain();
		start <= 0;
		while (board.exp_key.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Picks a key that often lands near the ends or repeats, so that equal
	// keys and sign boundaries get exercised.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(5))
			0: return $urandom_range(3);
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return 32'h8000_0000 + $urandom_range(3) - 2;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_set(int n, bit small_range);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			k = small_range ? $urandom_range(4) : pick_key();
			send_item(k, 16'($urandom), i == n - 1);
		end
	endtask

	initial begin
		int n;
		board = new();
		items_sent = 0;
		idle_pct = 0;
		arst_n = 0;
		start = 0;
		key = 0;
		tag = 0;
		last_item = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: a single element, field extremes, all-equal keys and
		// an overfull set that drops loads.
		write_reg(tqs_pkg::REG_SIGNED, 0);
		write_reg(tqs_pkg::REG_DESCENDING, 0);
		send_item(32'h1234_5678, 16'hFFFF, 1);
		drain();
		send_item(32'hFFFF_FFFF, 16'h0000, 0);
		send_item(32'h0000_0000, 16'hFFFF, 0);
		send_item(32'h8000_0000, 16'h0001, 0);
		send_item(32'h7FFF_FFFF, 16'h8000, 1);
		drain();
		write_reg(tqs_pkg::REG_SIGNED, 1);
		send_item(32'hFFFF_FFFF, 16'h0001, 0);
		send_item(32'h0000_0001, 16'h0002, 0);
		send_item(32'h8000_0000, 16'h0003, 1);
		drain();
		write_reg(tqs_pkg::REG_DESCENDING, 1);
		for (int i = 0; i < 5; i++) send_item(32'd7, 16'(i), i == 4);
		drain();
		// Overfull set: 66 loads, two dropped, and a dropped last item that
		// still starts the sort.
		write_reg(tqs_pkg::REG_SIGNED, 0);
		for (int i = 0; i < 66; i++) send_item($urandom, 16'($urandom), i == 65);
		drain();

		// Random sets in four idling phases, with a new register setting per
		// set; mostly small sets, a full one at the start of two phases.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 49 : (ph == 3) ? 26 : 0;
			for (int s = 0; s < 6; s++) begin
				write_reg(tqs_pkg::REG_SIGNED, 1'($urandom_range(1)));
				write_reg(tqs_pkg::REG_DESCENDING, 1'($urandom_range(1)));
				n = (s == 0 && (ph % 2) == 0) ? 64 : $urandom_range(1, 8);
				send_set(n, 1'($urandom_range(1)));
				drain();
			end
		end

		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
